### rtl/scf_pkg.sv
// Types and constants shared by the servo command framer modules.
package scf_pkg;

  // Header byte and frame layout constants.
  localparam logic [7:0] HDR_BYTE    = 8'h55;
  localparam logic [7:0] OP_MOVE     = 8'd1;
  localparam logic [7:0] LEN_MOVE    = 8'd7;
  localparam logic [7:0] OP_SET_ID   = 8'd13;
  localparam logic [7:0] LEN_SET_ID  = 8'd4;
  localparam logic [7:0] OP_READ_ID  = 8'd14;
  localparam logic [7:0] LEN_READ_ID = 8'd3;

  // Body byte counts (id through last parameter).
  localparam logic [2:0] NBODY_MOVE    = 3'd7;
  localparam logic [2:0] NBODY_SET_ID  = 3'd4;
  localparam logic [2:0] NBODY_READ_ID = 3'd3;

  // Number of header bytes ahead of the body.
  localparam logic [3:0] HDR_COUNT = 4'd2;

  // Command codes.
  localparam logic [1:0] CMD_MOVE    = 2'd0;
  localparam logic [1:0] CMD_SET_ID  = 2'd1;
  localparam logic [1:0] CMD_READ_ID = 2'd2;

  // One input beat.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic [15:0] move_time;
    logic [7:0]  new_id;
  } scf_cmd_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } scf_byte_t;

  // A classified frame waiting to be sent.
  typedef struct packed {
    logic [6:0][7:0] body;
    logic [2:0]      nbody;
    logic [7:0]      chk;
  } scf_frame_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic avail;
    logic pop;
  } scf_qctl_t;

endpackage

### rtl/scf_front.sv
// Front end: classifies a command and builds its frame body and checksum.
module scf_front import scf_pkg::*; (
  input  scf_cmd_t   cmd_in,
  output logic       known,
  output scf_frame_t frame
);

  logic [7:0] sum;

  // Lay out the body bytes for the selected opcode; unused slots stay zero.
  // Checksum is the inverted 8-bit sum of the body; zero slots add nothing.
  always_comb begin
    frame.body  = '0;
    frame.nbody = NBODY_READ_ID;
    known       = 1'b1;
    frame.body[0] = cmd_in.servo_id;
    case (cmd_in.cmd)
      CMD_MOVE: begin
        frame.body[1] = LEN_MOVE;
        frame.body[2] = OP_MOVE;
        frame.body[3] = cmd_in.position[7:0];
        frame.body[4] = cmd_in.position[15:8];
        frame.body[5] = cmd_in.move_time[7:0];
        frame.body[6] = cmd_in.move_time[15:8];
        frame.nbody   = NBODY_MOVE;
      end
      CMD_SET_ID: begin
        frame.body[1] = LEN_SET_ID;
        frame.body[2] = OP_SET_ID;
        frame.body[3] = cmd_in.new_id;
        frame.nbody   = NBODY_SET_ID;
      end
      CMD_READ_ID: begin
        frame.body[1] = LEN_READ_ID;
        frame.body[2] = OP_READ_ID;
        frame.nbody   = NBODY_READ_ID;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    sum = '0;
    for (int i = 0; i < 7; i++) begin
      sum = sum + frame.body[i];
    end
    frame.chk = ~sum;
  end

endmodule

### rtl/scf_queue.sv
// Small register queue of classified frames between front and back ends.
module scf_queue import scf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  scf_frame_t wr_frame,
  output logic       full,
  input  scf_qctl_t  ctl_in,
  output logic       avail,
  output scf_frame_t rd_frame
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scf_frame_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign avail    = (count != '0);
  assign do_pop   = ctl_in.pop & ctl_in.avail;
  assign rd_frame = slots[rd_ptr];

  // Frame storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wr_frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/scf_back.sv
// Back end: walks a queued frame and sends one byte per beat.
module scf_back import scf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  scf_frame_t frame,
  output scf_qctl_t  ctl_out,
  output logic       out_valid,
  input  logic       out_stall,
  output scf_byte_t  out_data
);

  logic [3:0] idx;
  logic [3:0] bidx;
  logic [3:0] last_idx;
  logic       load;
  logic       is_last;
  scf_byte_t  beat_next;

  assign load     = !out_valid || !out_stall;
  assign last_idx = {1'b0, frame.nbody} + HDR_COUNT;
  assign is_last  = (idx == last_idx);
  assign bidx     = idx - HDR_COUNT;

  // Pick the byte at the current frame position.
  always_comb begin
    beat_next.last = is_last;
    if (idx < HDR_COUNT) begin
      beat_next.tx_byte = HDR_BYTE;
    end else if (is_last) begin
      beat_next.tx_byte = frame.chk;
    end else begin
      beat_next.tx_byte = frame.body[bidx[2:0]];
    end
  end

  assign ctl_out.avail = q_avail;
  assign ctl_out.pop   = load && q_avail && is_last;

  // Output register and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= q_avail;
      if (q_avail) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_avail) begin
      out_data <= beat_next;
    end
  end

endmodule

### rtl/serial_servo_command_framer.sv
// Top level of the serial servo command framer.
//
//   Channel  Direction  Handshake            Beat
//   in       input      in_valid / in_stall  one command (scf_cmd_t)
//   out      output     out_valid / out_stall one frame byte (scf_byte_t)
//
// A command is classified in the cycle it is accepted and parked in the frame queue.
// The back end sends one byte per cycle while out_stall is low: 10, 7 or 6 bytes per frame for move,
// set id and read id, back to back with no gap between frames.
// An undefined command is accepted and produces no bytes.
// Synchronous reset empties the queue and drops any byte on the output.
// in_stall rises only while the queue is full; out_stall holds the current byte.
module serial_servo_command_framer import scf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  scf_cmd_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output scf_byte_t out_data
);

  scf_frame_t front_frame;
  scf_frame_t head_frame;
  logic       known;
  logic       full;
  logic       avail;
  scf_qctl_t  qctl;

  assign in_stall = full;

  scf_front u_front (
    .cmd_in (in_data),
    .known  (known),
    .frame  (front_frame)
  );

  scf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && known),
    .wr_frame (front_frame),
    .full     (full),
    .ctl_in   (qctl),
    .avail    (avail),
    .rd_frame (head_frame)
  );

  scf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (avail),
    .frame     (head_frame),
    .ctl_out   (qctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/scf_checker.sv
// Port-level checks for the servo command framer, bound to the top level.
module scf_checker import scf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input scf_byte_t out_data
);

  logic [3:0] pos;

  // Byte position inside the current frame, seen from the output port.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (out_valid && !out_stall) begin
      pos <= out_data.last ? '0 : ((pos == 4'd15) ? pos : pos + 1'b1);
    end
  end

  // Reset leaves no byte on the output.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled byte stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output byte changed");

  // Every frame opens with two header bytes.
  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pos < 4'd2) |-> (out_data.tx_byte == HDR_BYTE) && !out_data.last)
    else $error("frame header byte wrong");

  // The checksum byte ends a frame of six, seven or ten bytes.
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> (pos == 4'd5) || (pos == 4'd6) || (pos == 4'd9))
    else $error("frame length wrong");

endmodule

bind serial_servo_command_framer scf_checker u_scf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/serial_servo_command_framer_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every frame byte of the servo command framer and compares it.
module serial_servo_command_framer_checker import scf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  scf_cmd_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  scf_byte_t out_data,
  output int        error_count,
  output int        bytes_pending
);

  // Frame bytes still owed by the block, oldest first.
  scf_byte_t frame_bytes_due[$];
  scf_byte_t due_byte;
  int        byte_index = 0;

  // Builds the frame for one command and appends its bytes to the queue.
  // An undefined command yields no frame at all.
  function automatic void predict_frame(scf_cmd_t c);
    logic [7:0] body [7];
    int         body_len;
    logic [7:0] sum;
    body[0] = c.servo_id;
    case (c.cmd)
      CMD_MOVE: begin
        body[1]  = LEN_MOVE;
        body[2]  = OP_MOVE;
        body[3]  = c.position[7:0];
        body[4]  = c.position[15:8];
        body[5]  = c.move_time[7:0];
        body[6]  = c.move_time[15:8];
        body_len = 7;
      end
      CMD_SET_ID: begin
        body[1]  = LEN_SET_ID;
        body[2]  = OP_SET_ID;
        body[3]  = c.new_id;
        body_len = 4;
      end
      CMD_READ_ID: begin
        body[1]  = LEN_READ_ID;
        body[2]  = OP_READ_ID;
        body_len = 3;
      end
      default: begin
        body_len = 0;
      end
    endcase
    if (body_len == 0) return;
    frame_bytes_due.push_back('{tx_byte: HDR_BYTE, last: 1'b0});
    frame_bytes_due.push_back('{tx_byte: HDR_BYTE, last: 1'b0});
    // The checksum covers the id through the last parameter, then is inverted.
    sum = 8'h00;
    for (int i = 0; i < body_len; i++) begin
      sum = sum + body[i];
      frame_bytes_due.push_back('{tx_byte: body[i], last: 1'b0});
    end
    frame_bytes_due.push_back('{tx_byte: ~sum, last: 1'b1});
  endfunction

  // Commands are predicted before the output beat of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_frame(in_data);
      end
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b with no frame pending",
                   $time, out_data.tx_byte, out_data.last);
          error_count = error_count + 1;
        end else begin
          due_byte = frame_bytes_due.pop_front();
          if (out_data.tx_byte !== due_byte.tx_byte) begin
            $display("%0t: byte %0d tx_byte expected %02h, got %02h",
                     $time, byte_index, due_byte.tx_byte, out_data.tx_byte);
            error_count = error_count + 1;
          end
          if (out_data.last !== due_byte.last) begin
            $display("%0t: byte %0d last expected %0b, got %0b",
                     $time, byte_index, due_byte.last, out_data.last);
            error_count = error_count + 1;
          end
        end
        byte_index = byte_index + 1;
      end
    end
    bytes_pending = frame_bytes_due.size();
  end

endmodule

### dv/serial_servo_command_framer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the servo command framer: stimulus, output stalls and the verdict.
module serial_servo_command_framer_tb;
  import scf_pkg::*;

  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam int RANDOM_CMDS   = 250;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TAIL_CYCLES   = 20;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  scf_cmd_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  scf_byte_t out_data;
  int        error_count;
  int        bytes_pending;
  bit        steady_feed = 1'b0;
  int        stall_hold = 0;

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  serial_servo_command_framer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  serial_servo_command_framer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .error_count   (error_count),
    .bytes_pending (bytes_pending)
  );

  // Output stall in stretches: mostly short, some long, some long quiet runs.
  always @(negedge clk) begin
    int r;
    if (stall_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 7);
      end else if (r < 80) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (r < 90) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(30, 100);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(15, 50);
      end
    end else begin
      stall_hold = stall_hold - 1;
    end
  end

  // Idle cycles ahead of a command beat: mostly none or few, now and then many.
  function automatic int idle_gap();
    int r;
    if (steady_feed) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic scf_cmd_t make_cmd(logic [1:0] cmd, logic [7:0] sid,
                                        logic [15:0] pos, logic [15:0] tim,
                                        logic [7:0] nid);
    scf_cmd_t c;
    c.cmd       = cmd;
    c.servo_id  = sid;
    c.position  = pos;
    c.move_time = tim;
    c.new_id    = nid;
    return c;
  endfunction

  // Presents one command beat and holds it until accepted. Starts and ends at a falling edge.
  task automatic push_cmd(input scf_cmd_t c);
    int          gap;
    logic [63:0] noise;
    gap = idle_gap();
    if (gap > 0) begin
      noise = {$urandom, $urandom};
      in_valid <= 1'b0;
      in_data  <= noise[$bits(scf_cmd_t)-1:0];
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    scf_cmd_t c;
    int       cmds_sent;
    int       waited;
    int       r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes, checksum wrap to 0xFF and to 0x00, ignored fields, undefined commands.
    push_cmd(make_cmd(CMD_MOVE, 8'h00, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_MOVE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(CMD_MOVE, 8'h01, 16'h00FF, 16'hFF00, 8'h00));
    push_cmd(make_cmd(CMD_MOVE, 8'hFE, 16'h1234, 16'hABCD, 8'h5A));
    push_cmd(make_cmd(CMD_MOVE, 8'hF8, 16'h0000, 16'h0000, 8'hFF));
    push_cmd(make_cmd(CMD_MOVE, 8'hF7, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_SET_ID, 8'h00, 16'h0000, 16'h0000, 8'hFF));
    push_cmd(make_cmd(CMD_SET_ID, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00));
    push_cmd(make_cmd(CMD_SET_ID, 8'hEF, 16'h5555, 16'hAAAA, 8'h00));
    push_cmd(make_cmd(CMD_SET_ID, 8'hAA, 16'hFFFF, 16'h0000, 8'h55));
    push_cmd(make_cmd(CMD_READ_ID, 8'h00, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_READ_ID, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(CMD_READ_ID, 8'hEF, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_READ_ID, 8'hEE, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(CMD_UNDEFINED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_cmd(make_cmd(CMD_UNDEFINED, 8'h00, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_UNDEFINED, 8'h3C, 16'hC3C3, 16'h3C3C, 8'hC3));
    push_cmd(make_cmd(CMD_READ_ID, 8'h42, 16'h0000, 16'h0000, 8'h00));
    push_cmd(make_cmd(CMD_MOVE, 8'h80, 16'h8000, 16'h0080, 8'h80));
    push_cmd(make_cmd(CMD_SET_ID, 8'h7F, 16'h7FFF, 16'hFF7F, 8'h80));

    // Random commands with undefined ones mixed in.
    cmds_sent = 0;
    while (cmds_sent < RANDOM_CMDS) begin
      if (cmds_sent % 45 == 0) steady_feed = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) c.cmd = CMD_MOVE;
      else if (r < 65) c.cmd = CMD_SET_ID;
      else if (r < 90) c.cmd = CMD_READ_ID;
      else c.cmd = CMD_UNDEFINED;
      c.servo_id  = 8'($urandom_range(0, 255));
      c.position  = 16'($urandom_range(0, 65535));
      c.move_time = 16'($urandom_range(0, 65535));
      c.new_id    = 8'($urandom_range(0, 255));
      push_cmd(c);
      cmds_sent = cmds_sent + 1;
    end
    in_valid <= 1'b0;

    // Drain the outstanding frame bytes, then let the block settle.
    waited = 0;
    while (bytes_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited = waited + 1;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && bytes_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/scf_pkg.sv
rtl/scf_front.sv
rtl/scf_queue.sv
rtl/scf_back.sv
rtl/serial_servo_command_framer.sv
rtl/scf_checker.sv
dv/serial_servo_command_framer_checker.sv
dv/serial_servo_command_framer_tb.sv
